// File: rtl/assert_macros.svh
// Assertion macros shared by the receive FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define XRF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition never holds at a clock edge out of reset.
`define XRF_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define XRF_ASSERT(label, prop)
`define XRF_NEVER(label, cond)
`endif
`endif

// File: rtl/xrf_pkg.sv
// Types and constants of the XON/XOFF receive FIFO.
package xrf_pkg;

    localparam int XRF_DEPTH       = 8;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int LIMIT_W         = 4;
    localparam int FILL_W          = 4;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [7:0] PRINTABLE_MIN = 8'd32;
    localparam logic [7:0] LINE_FEED     = 8'd10;

    localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RESET = 4'd4;
    localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RESET = 4'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_LIMIT = 2'd1;

    typedef enum logic
    {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ACT_NONE = 2'd0,
        ACT_XOFF = 2'd1,
        ACT_XON  = 2'd2
    } flow_act_t;

    typedef enum logic
    {
        BK_IDLE  = 1'b0,
        BK_FETCH = 1'b1
    } back_state_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed
    {
        logic [7:0]        out_byte;
        logic              out_valid;
        logic              put_accepted;
        flow_act_t         flow_action;
        logic [FILL_W-1:0] fill_level;
    } result_t;

endpackage

// File: rtl/xrf_if.sv
// Channel interfaces: request, response and configuration write.
interface xrf_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, command, in_byte, input ready);
    modport sink   (input valid, command, in_byte, output ready);
endinterface

interface xrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       put_accepted;
    logic [1:0] flow_action;
    logic [3:0] fill_level;

    modport source (output valid, out_byte, out_valid, put_accepted, flow_action,
                    fill_level, input ready);
    modport sink   (input valid, out_byte, out_valid, put_accepted, flow_action,
                    fill_level, output ready);
endinterface

interface xrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/xrf_ram.sv
// Generic single-port-write, registered-read RAM.
module xrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/xrf_front.sv
// Front end: takes requests and classifies them into put or get commands.
module xrf_front (
    input  logic         clk,
    input  logic         rst_n,
    xrf_req_if.sink      req,
    output xrf_pkg::cmd_t cmd,
    output logic         cmd_valid,
    input  logic         cmd_ready
);
    import xrf_pkg::*;

    logic item_valid_reg;
    logic item_valid_next;
    cmd_t item_reg;
    logic take;

    assign req.ready = !item_valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op   <= req.command ? OP_GET : OP_PUT;
            item_reg.data <= req.in_byte;
        end
    end

    assign cmd       = item_reg;
    assign cmd_valid = item_valid_reg;

endmodule

// File: rtl/xrf_cmd_queue.sv
// Short command queue between the front end and the back end.
`include "assert_macros.svh"
module xrf_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  xrf_pkg::cmd_t push_cmd,
    input  logic          push_valid,
    output logic          push_ready,
    output xrf_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import xrf_pkg::*;

    localparam int QD    = CMD_QUEUE_DEPTH;
    localparam int QP_W  = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC_W  = $clog2(QD + 1);

    cmd_t             entry_reg [QD];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_next;
    logic [QC_W-1:0]  count_reg;
    logic [QC_W-1:0]  count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != QC_W'(QD));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // The occupancy never passes the number of entries.
    `XRF_ASSERT(a_count_bound, count_reg <= QC_W'(QD))
    // The pointers stay in step with the occupancy.
    `XRF_ASSERT(a_ptr_gap, (count_reg == '0 || count_reg == QC_W'(QD)) |-> wr_ptr_reg == rd_ptr_reg)
    // After a push with no pop, the queue is never empty.
    `XRF_ASSERT(a_pop_after_push, $past(push) && !$past(pop) |-> pop_valid)

endmodule

// File: rtl/xrf_back.sv
// Back end: runs put and get commands against the byte store.
`include "assert_macros.svh"
module xrf_back #(
    parameter int DEPTH = xrf_pkg::XRF_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  xrf_pkg::cmd_t               cmd,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [xrf_pkg::LIMIT_W-1:0] upper_limit,
    input  logic [xrf_pkg::LIMIT_W-1:0] lower_limit,
    xrf_rsp_if.source                   rsp
);
    import xrf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic             stopped_reg;
    logic             stopped_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    result_t          res_reg;
    result_t          res_next;
    logic             res_load;
    logic             slot_free;

    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [7:0]       ram_rd_data;

    logic [CNT_W-1:0] put_count;
    logic [CMP_W-1:0] put_count_wide;
    logic [CMP_W-1:0] held_wide;
    logic [CMP_W-1:0] held_next_wide;
    logic [CMP_W-1:0] upper_wide;
    logic [CMP_W-1:0] lower_wide;
    logic             store_full;
    logic             keep_popping;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign slot_free      = !res_valid_reg || rsp.ready;
    assign store_full     = (held_reg == CNT_W'(DEPTH));
    assign put_count      = store_full ? held_reg : held_reg + 1'b1;
    assign put_count_wide = CMP_W'(put_count);
    assign held_wide      = CMP_W'(held_reg);
    assign held_next_wide = CMP_W'(held_next);
    assign upper_wide     = CMP_W'(upper_limit);
    assign lower_wide     = CMP_W'(lower_limit);
    assign rd_ptr_inc     = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc     = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign keep_popping   = (ram_rd_data < PRINTABLE_MIN) && (ram_rd_data != LINE_FEED)
                            && (held_reg != '0);

    always_comb
    begin
        state_next   = state_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        cmd_ready    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        res_load     = 1'b0;
        res_next     = res_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_ready             = 1'b1;
                    res_next.out_byte     = '0;
                    res_next.out_valid    = 1'b0;
                    res_next.put_accepted = 1'b0;
                    res_next.flow_action  = ACT_NONE;
                    if (cmd.op == OP_PUT)
                    begin
                        res_load = 1'b1;
                        if (!stopped_reg)
                        begin
                            if (!store_full)
                            begin
                                ram_wr_en             = 1'b1;
                                wr_ptr_next           = wr_ptr_inc;
                                held_next             = put_count;
                                res_next.put_accepted = 1'b1;
                            end
                            if (put_count_wide > upper_wide)
                            begin
                                stopped_next         = 1'b1;
                                res_next.flow_action = ACT_XOFF;
                            end
                        end
                    end
                    else if (held_reg == '0)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                        held_next   = held_reg - 1'b1;
                        state_next  = BK_FETCH;
                    end
                end
            end
            BK_FETCH:
            begin
                if (keep_popping)
                begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_inc;
                    held_next   = held_reg - 1'b1;
                end
                else
                begin
                    res_load              = 1'b1;
                    res_next.out_byte     = ram_rd_data;
                    res_next.out_valid    = 1'b1;
                    res_next.put_accepted = 1'b0;
                    res_next.flow_action  = ACT_NONE;
                    if ((held_wide < lower_wide) && stopped_reg)
                    begin
                        stopped_next         = 1'b0;
                        res_next.flow_action = ACT_XON;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_next.fill_level = held_next_wide[FILL_W-1:0];

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            held_reg      <= '0;
            stopped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            held_reg      <= held_next;
            stopped_reg   <= stopped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    xrf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (cmd.data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign rsp.valid        = res_valid_reg;
    assign rsp.out_byte     = res_reg.out_byte;
    assign rsp.out_valid    = res_reg.out_valid;
    assign rsp.put_accepted = res_reg.put_accepted;
    assign rsp.flow_action  = res_reg.flow_action;
    assign rsp.fill_level   = res_reg.fill_level;

    // The store never holds more bytes than it has entries.
    `XRF_ASSERT(a_held_bound, held_reg <= CNT_W'(DEPTH))
    // An XON request only ever ends a get that popped a byte.
    `XRF_ASSERT(a_xon_on_get, (res_valid_reg && res_reg.flow_action == ACT_XON) |-> res_reg.out_valid)
    // A result is never both a stored put and a popped byte.
    `XRF_NEVER(a_put_and_pop, res_valid_reg && res_reg.put_accepted && res_reg.out_valid)
    // A fetch is only ever entered with a pop already issued.
    `XRF_ASSERT(a_fetch_entry, (state_reg == BK_FETCH && $past(state_reg) == BK_IDLE) |-> $past(ram_rd_en))

endmodule

// File: rtl/xon_xoff_receive_fifo.sv
// Top level of the XON/XOFF flow-controlled receive FIFO.
//
// The block keeps a circular store of DEPTH received bytes and produces exactly
// one response for every request. A put (command 0) stores in_byte unless the
// flow state is XOFF or the store is full, and asks for XOFF when the fill level
// then rises above upper_limit. A get (command 1) pops bytes until it meets a
// printable byte (32 or above) or a line feed, or the store runs dry, returns the
// last byte popped, and asks for XON when the level then drops below lower_limit
// while the flow is stopped. A request passes a front register and a
// two-entry command queue before the back end runs it. There a put, and a get on
// an empty store, run in the idle state; any other get issues its first read
// there and pops further bytes in the fetch state, as the registered read of the
// byte store delivers one byte per cycle to the pop loop. New requests are taken
// into the queue while it has room, even when the back end is busy or a response
// waits to be collected. The limit registers should only be written while the
// block is idle; writes to indexes other than the two limits are ignored.
module xon_xoff_receive_fifo #(
    parameter int DEPTH = xrf_pkg::XRF_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    xrf_req_if.sink   req,
    xrf_rsp_if.source rsp,
    xrf_cfg_if.sink   cfg
);
    import xrf_pkg::*;

    // Flow-control thresholds, written through the configuration channel.
    logic [LIMIT_W-1:0] upper_limit_reg;
    logic [LIMIT_W-1:0] lower_limit_reg;

    // Commands from the front end towards the queue, and from the queue onwards.
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    // Configuration writes are always taken at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= UPPER_LIMIT_RESET;
            lower_limit_reg <= LOWER_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_UPPER_LIMIT:
                begin
                    upper_limit_reg <= cfg.data;
                end
                CFG_LOWER_LIMIT:
                begin
                    lower_limit_reg <= cfg.data;
                end
                default:
                begin
                    // Unknown register indexes have no effect.
                end
            endcase
        end
    end

    // The front end registers each request and tags it as a put or a get.
    xrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // The queue lets the front end keep accepting while a long get runs.
    xrf_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // The back end owns the byte store, the pointers, the fill level and the
    // flow state, and holds each response until it is collected.
    xrf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (queue_cmd),
        .cmd_valid   (queue_valid),
        .cmd_ready   (queue_ready),
        .upper_limit (upper_limit_reg),
        .lower_limit (lower_limit_reg),
        .rsp         (rsp)
    );

endmodule

// File: sim/xrf_checker.sv
`timescale 1ns / 1ps
// Response checker for the XON/XOFF receive FIFO: predicts every response and compares it.
module xrf_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic       req_command,
    input  logic [7:0] req_in_byte,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic [7:0] rsp_out_byte,
    input  logic       rsp_out_valid,
    input  logic       rsp_put_accepted,
    input  logic [1:0] rsp_flow_action,
    input  logic [3:0] rsp_fill_level,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output int         failures,
    output int         pending,
    output int         requests_seen,
    output int         xoff_seen,
    output int         xon_seen,
    output int         refused_seen
);
    import xrf_pkg::*;

    localparam int DEPTH = XRF_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 50;

    typedef logic [PTR_W-1:0] slot_t;

    logic [7:0]         rx_store [DEPTH];
    slot_t              rd_slot;
    slot_t              wr_slot;
    logic [FILL_W-1:0]  held;
    logic               flow_off;
    logic [LIMIT_W-1:0] upper_limit;
    logic [LIMIT_W-1:0] lower_limit;
    result_t            due_responses [$];

    function automatic slot_t next_slot(input slot_t s);
        return (s == slot_t'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // One request applied to the predicted FIFO state.
    task automatic fifo_step(input op_t op, input logic [7:0] din, output result_t res);
        logic [7:0] popped;
        res = '0;
        res.flow_action = ACT_NONE;
        if (op == OP_PUT)
        begin
            if (!flow_off)
            begin
                if (held < DEPTH)
                begin
                    rx_store[wr_slot] = din;
                    wr_slot = next_slot(wr_slot);
                    held = held + 1'b1;
                    res.put_accepted = 1'b1;
                end
                if (held > upper_limit)
                begin
                    flow_off = 1'b1;
                    res.flow_action = ACT_XOFF;
                end
            end
        end
        else if (held != 0)
        begin
            do
            begin
                popped = rx_store[rd_slot];
                rd_slot = next_slot(rd_slot);
                held = held - 1'b1;
            end
            while (popped < PRINTABLE_MIN && popped != LINE_FEED && held != 0);
            res.out_byte = popped;
            res.out_valid = 1'b1;
            if (held < lower_limit && flow_off)
            begin
                flow_off = 1'b0;
                res.flow_action = ACT_XON;
            end
        end
        res.fill_level = held;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            rd_slot = '0;
            wr_slot = '0;
            held = '0;
            flow_off = 1'b0;
            upper_limit = UPPER_LIMIT_RESET;
            lower_limit = LOWER_LIMIT_RESET;
            due_responses.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_UPPER_LIMIT)
                    upper_limit = cfg_data;
                else if (cfg_index == CFG_LOWER_LIMIT)
                    lower_limit = cfg_data;
            end
            if (req_valid && req_ready)
            begin
                fifo_step(op_t'(req_command), req_in_byte, want);
                due_responses.push_back(want);
                requests_seen++;
                if (want.flow_action == ACT_XOFF)
                    xoff_seen++;
                if (want.flow_action == ACT_XON)
                    xon_seen++;
                if (op_t'(req_command) == OP_PUT && !want.put_accepted)
                    refused_seen++;
            end
            if (rsp_valid && rsp_ready)
            begin
                got.out_byte     = rsp_out_byte;
                got.out_valid    = rsp_out_valid;
                got.put_accepted = rsp_put_accepted;
                got.flow_action  = flow_act_t'(rsp_flow_action);
                got.fill_level   = rsp_fill_level;
                if (due_responses.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: response with none expected, expected nothing, actual %0h",
                                 $time, got);
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, got.out_byte);
                    if (got.out_valid !== want.out_valid)
                        report_mismatch("out_valid", want.out_valid, got.out_valid);
                    if (got.put_accepted !== want.put_accepted)
                        report_mismatch("put_accepted", want.put_accepted, got.put_accepted);
                    if (got.flow_action !== want.flow_action)
                        report_mismatch("flow_action", want.flow_action, got.flow_action);
                    if (got.fill_level !== want.fill_level)
                        report_mismatch("fill_level", want.fill_level, got.fill_level);
                end
            end
            pending = due_responses.size();
        end
    end

endmodule

// File: sim/tb_xon_xoff_receive_fifo.sv
`timescale 1ns / 1ps
// Testbench top for the XON/XOFF receive FIFO: clock, reset, stimulus and verdict.
module tb_xon_xoff_receive_fifo;
    import xrf_pkg::*;

    // A generous ceiling on the length of a correct run.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 100;

    // Per-phase handshake mix and limit settings. The last phase draws its limits at
    // random; the others pin the extremes, a hysteresis band and an inverted band.
    int send_idle_mix [RANDOM_PHASES] = '{0, 55, 0, 28, 0};
    int stall_mix     [RANDOM_PHASES] = '{0, 0, 55, 28, 0};
    int upper_mix     [RANDOM_PHASES] = '{6, 0, 15, 3, 7};
    int lower_mix     [RANDOM_PHASES] = '{2, 15, 0, 8, 4};

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int cycles;

    int failures;
    int pending;
    int requests_seen;
    int xoff_seen;
    int xon_seen;
    int refused_seen;

    xrf_req_if req_ch ();
    xrf_rsp_if rsp_ch ();
    xrf_cfg_if cfg_ch ();

    xon_xoff_receive_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    xrf_checker rsp_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_ch.valid),
        .req_ready        (req_ch.ready),
        .req_command      (req_ch.command),
        .req_in_byte      (req_ch.in_byte),
        .rsp_valid        (rsp_ch.valid),
        .rsp_ready        (rsp_ch.ready),
        .rsp_out_byte     (rsp_ch.out_byte),
        .rsp_out_valid    (rsp_ch.out_valid),
        .rsp_put_accepted (rsp_ch.put_accepted),
        .rsp_flow_action  (rsp_ch.flow_action),
        .rsp_fill_level   (rsp_ch.fill_level),
        .cfg_valid        (cfg_ch.valid),
        .cfg_ready        (cfg_ch.ready),
        .cfg_index        (cfg_ch.index),
        .cfg_data         (cfg_ch.data),
        .failures         (failures),
        .pending          (pending),
        .requests_seen    (requests_seen),
        .xoff_seen        (xoff_seen),
        .xon_seen         (xon_seen),
        .refused_seen     (refused_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: if the run has not finished by the limit, something has hung.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_xon_xoff_receive_fifo failed");
        $finish;
    end

    // Response side. A long hold-off, when one is asked for, is counted down here one
    // cycle at a time; otherwise ready is dropped at random at the phase's stall rate.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Bytes are skewed towards the interesting classes: line feeds and control
    // characters that a get skips over, with the rest spread over the whole range.
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return LINE_FEED;
        else if (roll < 45)
            return 8'($urandom_range(31));
        else
            return 8'($urandom_range(255));
    endfunction

    // Offers one request after a random idle gap and waits for the handshake. When no
    // gap is drawn, valid simply stays high and only the payload changes.
    task automatic send_request(input op_t op, input logic [7:0] payload);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.command <= op;
        req_ch.in_byte <= payload;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering and waits until every predicted response has been collected.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random traffic shaped like a real link: bursts of received bytes followed by a
    // few reads, so that the fill level climbs through the upper limit and falls back
    // through the lower one. About one request in ten goes against the grain of its
    // burst to break the pattern up.
    task automatic run_traffic(input int n_requests);
        int issued;
        int burst;
        int k;
        issued = 0;
        while (issued < n_requests)
        begin
            burst = $urandom_range(1, 10);
            for (k = 0; k < burst; k++)
            begin
                if ($urandom_range(99) < 10)
                    send_request(OP_GET, 8'($urandom_range(255)));
                else
                    send_request(OP_PUT, pick_byte());
            end
            issued += burst;
            burst = $urandom_range(1, 6);
            for (k = 0; k < burst; k++)
            begin
                if ($urandom_range(99) < 10)
                    send_request(OP_PUT, pick_byte());
                else
                    send_request(OP_GET, 8'($urandom_range(255)));
            end
            issued += burst;
        end
    endtask

    initial
    begin
        int p;
        int k;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = OP_PUT;
        req_ch.in_byte = 8'h00;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_UPPER_LIMIT;
        cfg_ch.data    = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset limits (XOFF above four, XON below one).
        // The fifth put crosses the upper limit and requests XOFF; the sixth arrives in
        // the XOFF state and must be refused. The first get skips a NUL and returns the
        // 0xFF behind it, the second stops at the line feed, the third skips a control
        // character, empties the store and requests XON. The last get finds it empty.
        send_request(OP_PUT, 8'h00);
        send_request(OP_PUT, 8'hFF);
        send_request(OP_PUT, LINE_FEED);
        send_request(OP_PUT, 8'h1F);
        send_request(OP_PUT, PRINTABLE_MIN);
        send_request(OP_PUT, 8'h55);
        send_request(OP_GET, 8'hFF);
        send_request(OP_GET, 8'h00);
        send_request(OP_GET, 8'hAA);
        send_request(OP_GET, 8'h55);
        wait_drained();

        // With the upper limit at the full depth and the lower limit at zero the store
        // fills completely without XOFF, a put into the full store is refused, and one
        // get drains eight control characters and returns the last of them.
        write_limit(CFG_UPPER_LIMIT, 4'd8);
        write_limit(CFG_LOWER_LIMIT, 4'd0);
        for (k = 1; k <= XRF_DEPTH; k++)
            send_request(OP_PUT, 8'(k));
        send_request(OP_PUT, 8'hAA);
        send_request(OP_GET, 8'h00);
        send_request(OP_GET, 8'h00);
        wait_drained();

        // Random phases. Limits change only once every response is in, so the block
        // is idle at each write.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                write_limit(CFG_UPPER_LIMIT, 4'($urandom_range(15)));
                write_limit(CFG_LOWER_LIMIT, 4'($urandom_range(15)));
            end
            else
            begin
                write_limit(CFG_UPPER_LIMIT, 4'(upper_mix[p]));
                write_limit(CFG_LOWER_LIMIT, 4'(lower_mix[p]));
            end
            send_idle_pct = send_idle_mix[p];
            stall_pct     = stall_mix[p];
            run_traffic(PHASE_REQUESTS / 2);
            if (p == 0)
            begin
                // Hold responses back for a long stretch while requests keep coming, so
                // that the internal queue fills and the request side is stalled.
                hold_left = 80;
            end
            else if (p == 3)
            begin
                // Pause the sender mid-phase until the block has answered everything.
                wait_drained();
            end
            run_traffic(PHASE_REQUESTS - PHASE_REQUESTS / 2);
            wait_drained();
        end

        // Allow for a stray response after the last expected one, in case a get that
        // pops the whole store is still running in the back end.
        repeat (2 * XRF_DEPTH + 4) @(negedge clk);

        $display("Covered %0d requests under %0d limit settings and %0d random phases,",
                 requests_seen, RANDOM_PHASES + 2, RANDOM_PHASES);
        $display("including a long response hold-off: %0d XOFF, %0d XON, %0d puts refused.",
                 xoff_seen, xon_seen, refused_seen);
        if (failures == 0 && pending == 0)
            $display("tb_xon_xoff_receive_fifo passed");
        else
            $display("tb_xon_xoff_receive_fifo failed");
        $finish;
    end

endmodule
